[rtl/core/b64_pkg.sv]
// Shared types, constants and symbol lookup for the Base64 stream decoder.
`default_nettype none

package b64_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BcW      = 24;
  localparam int unsigned AccW     = 24;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned ResCntW  = 3;

  localparam logic [CharW-1:0] ChUpA  = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChUpZ  = 8'h5A;  // 'Z'
  localparam logic [CharW-1:0] ChLoA  = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChLoZ  = 8'h7A;  // 'z'
  localparam logic [CharW-1:0] ChDig0 = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChDig9 = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChPlus = 8'h2B;  // '+'
  localparam logic [CharW-1:0] ChSlsh = 8'h2F;  // '/'
  localparam logic [CharW-1:0] ChPad  = 8'h3D;  // '='

  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusVal   = 6'd62;
  localparam logic [5:0] SlashVal  = 6'd63;

  typedef enum logic [2:0] {
    StData     = 3'd0,
    StDone     = 3'd1,
    StBadSym   = 3'd2,
    StTrunc    = 3'd3,
    StOverflow = 3'd4
  } b64_status_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             is_last;
  } b64_in_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    b64_status_e      status;
    logic [BcW-1:0]   byte_count;
    logic             end_of_run;
  } b64_out_t;

  // results produced by one character, in delivery order
  typedef struct packed {
    logic [ResCntW-1:0]      num;
    b64_out_t [MaxRes-1:0]   ent;
  } b64_bundle_t;

  typedef struct packed {
    logic       ok;
    logic       pad;
    logic [5:0] val;
  } b64_sym_t;

  function automatic b64_sym_t b64_lookup(logic [CharW-1:0] c);
    b64_sym_t s;
    logic [CharW-1:0] d;
    s = '0;
    d = '0;
    if (c >= ChUpA && c <= ChUpZ) begin
      d = c - ChUpA;
      s.ok = 1'b1;
      s.val = d[5:0];
    end else if (c >= ChLoA && c <= ChLoZ) begin
      d = c - ChLoA;
      s.ok = 1'b1;
      s.val = d[5:0] + LowerBase;
    end else if (c >= ChDig0 && c <= ChDig9) begin
      d = c - ChDig0;
      s.ok = 1'b1;
      s.val = d[5:0] + DigitBase;
    end else if (c == ChPlus) begin
      s.ok = 1'b1;
      s.val = PlusVal;
    end else if (c == ChSlsh) begin
      s.ok = 1'b1;
      s.val = SlashVal;
    end else if (c == ChPad) begin
      s.ok = 1'b1;
      s.pad = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/core/b64_group.sv]
// Group state and per-character result computation.
`default_nettype none

module b64_group import b64_pkg::*; #(
  parameter int unsigned CntW = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [BcW-1:0] max_bytes_i,
  input  b64_in_t        item_i,
  input  logic           advance_i,
  output b64_bundle_t    bundle_o
);

  localparam int unsigned CmpW = CntW + 1 + BcW;

  logic [AccW-1:0] acc_q, acc_d;
  logic [1:0]      pos_q, pos_d;
  logic [1:0]      ph_q, ph_d;
  logic [CntW-1:0] total_q, total_d;
  logic            disc_q, disc_d;

  b64_sym_t        sym;
  logic [AccW-1:0] acc_new;
  logic [1:0]      ph_new;
  logic [1:0]      cnt;
  logic [CntW:0]   sum;
  logic            over;
  logic [CntW-1:0] run;
  logic [ByteW-1:0] bytes [3];

  assign sym    = b64_lookup(item_i.char_code);
  assign ph_new = {ph_q[0], sym.pad};
  assign bytes[0] = acc_new[23:16];
  assign bytes[1] = acc_new[15:8];
  assign bytes[2] = acc_new[7:0];

  always_comb begin
    case (pos_q)
      2'd0:    acc_new = acc_q | {sym.val, 18'd0};
      2'd1:    acc_new = acc_q | {6'd0, sym.val, 12'd0};
      2'd2:    acc_new = acc_q | {12'd0, sym.val, 6'd0};
      default: acc_new = acc_q | {18'd0, sym.val};
    endcase
  end

  always_comb begin
    cnt = 2'd3;
    if (item_i.is_last && ph_new[0]) begin
      cnt = ph_new[1] ? 2'd1 : 2'd2;
    end
    sum  = {1'b0, total_q} + (CntW+1)'(cnt);
    // carry out means the counter itself would wrap
    over = sum[CntW] || (CmpW'(sum) > CmpW'(max_bytes_i));
  end

  always_comb begin
    acc_d    = acc_q;
    pos_d    = pos_q;
    ph_d     = ph_q;
    total_d  = total_q;
    disc_d   = disc_q;
    bundle_o = '0;
    run      = total_q;

    if (disc_q) begin
      if (item_i.is_last) begin
        disc_d = 1'b0;
      end
    end else if (!sym.ok) begin
      bundle_o.num              = ResCntW'(1);
      bundle_o.ent[0].status     = StBadSym;
      bundle_o.ent[0].byte_count = BcW'(total_q);
      bundle_o.ent[0].end_of_run = 1'b1;
      acc_d   = '0;
      pos_d   = '0;
      ph_d    = '0;
      total_d = '0;
      disc_d  = !item_i.is_last;
    end else if (pos_q != 2'd3) begin
      acc_d = acc_new;
      ph_d  = ph_new;
      pos_d = pos_q + 2'd1;
      if (item_i.is_last) begin
        bundle_o.num              = ResCntW'(1);
        bundle_o.ent[0].status     = StTrunc;
        bundle_o.ent[0].byte_count = BcW'(total_q);
        bundle_o.ent[0].end_of_run = 1'b1;
        acc_d   = '0;
        pos_d   = '0;
        ph_d    = '0;
        total_d = '0;
      end
    end else if (over) begin
      // nothing of the group goes out
      bundle_o.num              = ResCntW'(1);
      bundle_o.ent[0].status     = StOverflow;
      bundle_o.ent[0].byte_count = BcW'(total_q);
      bundle_o.ent[0].end_of_run = 1'b1;
      acc_d   = '0;
      pos_d   = '0;
      ph_d    = '0;
      total_d = '0;
      disc_d  = !item_i.is_last;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt) begin
          run = run + CntW'(1);
          bundle_o.ent[i].data_byte  = bytes[i];
          bundle_o.ent[i].status     = StData;
          bundle_o.ent[i].byte_count = BcW'(run);
          bundle_o.ent[i].end_of_run = !item_i.is_last && (2'(i + 1) == cnt);
        end
      end
      acc_d   = '0;
      pos_d   = '0;
      ph_d    = '0;
      total_d = sum[CntW-1:0];
      if (item_i.is_last) begin
        bundle_o.ent[cnt].status     = StDone;
        bundle_o.ent[cnt].byte_count = BcW'(sum[CntW-1:0]);
        bundle_o.ent[cnt].end_of_run = 1'b1;
        bundle_o.num = ResCntW'(cnt) + ResCntW'(1);
        total_d = '0;
      end else begin
        bundle_o.num = ResCntW'(cnt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pos_q   <= '0;
      ph_q    <= '0;
      total_q <= '0;
      disc_q  <= 1'b0;
    end else if (advance_i) begin
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      ph_q    <= ph_d;
      total_q <= total_d;
      disc_q  <= disc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/b64_obuf.sv]
// Result buffer: holds one character's results and hands them out one per cycle while out_stall_i is low.
`default_nettype none

module b64_obuf import b64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  b64_bundle_t bundle_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output b64_out_t    out_data_o
);

  logic [ResCntW-1:0] rem_q, rem_d;
  logic [1:0]         head_q, head_d;
  b64_out_t [MaxRes-1:0] ent_q;
  logic               take;

  assign out_valid_o = (rem_q != '0);
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = (rem_q == '0) || ((rem_q == ResCntW'(1)) && take);
  assign out_data_o  = ent_q[head_q];

  always_comb begin
    rem_d  = rem_q;
    head_d = head_q;
    if (load_i) begin
      rem_d  = bundle_i.num;
      head_d = '0;
    end else if (take) begin
      rem_d  = rem_q - ResCntW'(1);
      head_d = head_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      head_q <= '0;
    end else begin
      rem_q  <= rem_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= bundle_i.ent;
    end
  end

endmodule

`default_nettype wire

[rtl/core/base64_stream_decoder_top.sv]
// Top level of the Base64 stream decoder.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | to block  | in_valid_i / in_stall_o | b64_in_t  (char_code, is_last)
//  out     | from blk  | out_valid_o/out_stall_i | b64_out_t (byte, status, count,
//          |           |                         |            end_of_run)
//  cfg     | to block  | cfg_valid_i/cfg_ready_o | max_output_bytes, 24 bits
//
// A character is registered on acceptance and decoded from that register; its
// results are loaded into the result buffer when it advances, and the first of
// them shows on the port from that buffer.
// One character per cycle is taken while the results fit the output port: a
// character with no result never waits, one with results waits until the
// four-entry result buffer has handed out its last entry, one per cycle while out_stall_i is low.
// A full group thus gives 3 or 4 results, all handed out through the single result port.
// Reset clears all decoding state and sets the byte limit to its maximum.
// A stall on the output backs up into in_stall_o in the same cycle.
`default_nettype none

module base64_stream_decoder_top import b64_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  b64_in_t        in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output b64_out_t       out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [BcW-1:0] cfg_data_i
);

  logic [BcW-1:0] max_q;
  logic           in_vld_q;
  b64_in_t        in_q;
  logic           in_take;
  logic           advance;
  logic           buf_free;
  b64_bundle_t    bundle;

  // register is always writable; writes must only come while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '1;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // characters with no results move on even while the buffer drains
  assign advance    = in_vld_q && ((bundle.num == '0) || buf_free);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  b64_group #(
    .CntW(COUNT_WIDTH)
  ) u_group (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_bytes_i(max_q),
    .item_i     (in_q),
    .advance_i  (advance),
    .bundle_o   (bundle)
  );

  b64_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && (bundle.num != '0)),
    .bundle_i   (bundle),
    .free_o     (buf_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/core/b64_checker.sv]
// Port-level checks for the Base64 stream decoder, bound to the top level.
`default_nettype none

module b64_checker import b64_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  b64_out_t       out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StData) |-> out_data_o.end_of_run)
    else $error("status result not marked end of run");

  a_status_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StData) |-> (out_data_o.data_byte == '0))
    else $error("status result carries a data byte");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StData || out_data_o.status == StDone ||
                     out_data_o.status == StBadSym || out_data_o.status == StTrunc ||
                     out_data_o.status == StOverflow))
    else $error("undefined status code");

endmodule

bind base64_stream_decoder_top b64_checker u_b64_checker (.*);

`default_nettype wire

[sim/b64_decode_checker.sv]
// Watches the decoder's channels, predicts each request's results and compares them.
module b64_decode_checker import b64_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  b64_in_t        in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  b64_out_t       out_data_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [BcW-1:0] cfg_data_i,
  output int             mismatches_o,
  output int             results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state
  logic [BcW-1:0]  byte_limit;
  logic [AccW-1:0] acc_bits;
  logic [1:0]      sym_count;
  logic [1:0]      pad_bits;
  logic [BcW-1:0]  bytes_out;
  logic            dropping;

  b64_out_t decoded_q[$];

  function automatic int sym_of(logic [CharW-1:0] c);
    if (c >= ChUpA && c <= ChUpZ) return int'(c - ChUpA);
    if (c >= ChLoA && c <= ChLoZ) return int'(c - ChLoA) + 26;
    if (c >= ChDig0 && c <= ChDig9) return int'(c - ChDig0) + 52;
    if (c == ChPlus) return 62;
    if (c == ChSlsh) return 63;
    if (c == ChPad) return 0;
    return -1;
  endfunction

  task automatic clear_text();
    acc_bits  = '0;
    sym_count = '0;
    pad_bits  = '0;
    bytes_out = '0;
    dropping  = 1'b0;
  endtask

  task automatic add_result(input logic [ByteW-1:0] b, input b64_status_e st,
                            input logic [BcW-1:0] cnt, input logic eor);
    b64_out_t r;
    r.data_byte  = b;
    r.status     = st;
    r.byte_count = cnt;
    r.end_of_run = eor;
    decoded_q.push_back(r);
  endtask

  // error status ends the text, or starts dropping up to its last character
  task automatic flag_error(input b64_status_e st, input logic last);
    add_result('0, st, bytes_out, 1'b1);
    clear_text();
    if (!last) dropping = 1'b1;
  endtask

  task automatic decode_char(input b64_in_t req);
    int          v;
    int          sh;
    int unsigned n_bytes;
    logic [BcW:0] sum;
    if (dropping) begin
      if (req.is_last) clear_text();
      return;
    end
    v = sym_of(req.char_code);
    if (v < 0) begin
      flag_error(StBadSym, req.is_last);
      return;
    end
    sh = 18 - 6 * int'(sym_count);
    acc_bits = acc_bits | (AccW'(v) << sh);
    pad_bits = {pad_bits[0], req.char_code == ChPad};
    if (sym_count < 2'd3) begin
      sym_count = sym_count + 2'd1;
      if (req.is_last) flag_error(StTrunc, 1'b1);
      return;
    end
    n_bytes = 3;
    if (req.is_last && pad_bits[0]) n_bytes = pad_bits[1] ? 1 : 2;
    // whole group is refused if it would pass the limit
    sum = {1'b0, bytes_out} + (BcW+1)'(n_bytes);
    if (sum > {1'b0, byte_limit}) begin
      flag_error(StOverflow, req.is_last);
      return;
    end
    for (int i = 0; i < int'(n_bytes); i++) begin
      add_result(ByteW'(acc_bits >> (16 - 8 * i)), StData, bytes_out + BcW'(i + 1),
                 !req.is_last && (i == int'(n_bytes) - 1));
    end
    bytes_out = bytes_out + BcW'(n_bytes);
    acc_bits  = '0;
    sym_count = '0;
    pad_bits  = '0;
    if (req.is_last) begin
      add_result('0, StDone, bytes_out, 1'b1);
      clear_text();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    b64_out_t want;
    if (!rst_ni) begin
      byte_limit = '1;
      clear_text();
      decoded_q.delete();
      mismatches_o  = 0;
      results_due_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected result: expected none, got byte %h status %0d count %0d end %b",
                   $time, out_data_i.data_byte, out_data_i.status, out_data_i.byte_count,
                   out_data_i.end_of_run);
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.data_byte !== want.data_byte || out_data_i.status !== want.status ||
              out_data_i.byte_count !== want.byte_count ||
              out_data_i.end_of_run !== want.end_of_run) begin
            mismatches_o++;
            $display("%0t: result mismatch: expected byte %h status %0d count %0d end %b",
                     $time, want.data_byte, want.status, want.byte_count, want.end_of_run);
            $display("%0t:                  actual   byte %h status %0d count %0d end %b",
                     $time, out_data_i.data_byte, out_data_i.status, out_data_i.byte_count,
                     out_data_i.end_of_run);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) byte_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) decode_char(in_data_i);
      results_due_o = decoded_q.size();
    end
  end

endmodule

[sim/base64_stream_decoder_top_test.sv]
// Stimulus and verdict for the Base64 stream decoder, checked by b64_decode_checker.
module base64_stream_decoder_top_test;
  import b64_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 100000;
  localparam int LatencyCycles = 8;    // margin for a request to pass the input register and the result buffer
  localparam int HoldCycles    = 300;  // long receiver hold-off, fills the block
  localparam int PhaseChars    = 18;   // random characters per limit setting

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  b64_in_t        in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  b64_out_t       out_data_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [BcW-1:0] cfg_data_i;

  int mismatches;
  int results_due;

  // shared between sender and receiver: idle chance in percent
  int   gap_pct   = 20;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   sent_chars = 0;

  logic [CharW-1:0] text_q[$];

  base64_stream_decoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  b64_decode_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .results_due_o(results_due)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog: a hang anywhere ends the run as a failure
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("base64_stream_decoder_top_test: FAIL");
    $finish;
  end

  // Result side. Random stall at gap_pct; once asked, one long hold-off counted
  // here while the sender keeps offering, so the result buffer fills and the
  // input side backs up.
  initial begin : result_sink
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < gap_pct);
    end
  end

  function automatic logic [CharW-1:0] b64_char(int unsigned idx);
    if (idx < 26) return ChUpA + CharW'(idx);
    if (idx < 52) return ChLoA + CharW'(idx - 26);
    if (idx < 62) return ChDig0 + CharW'(idx - 52);
    if (idx == 62) return ChPlus;
    return ChSlsh;
  endfunction

  // Offer one character and hold it until the request is taken; sometimes
  // drop valid for a random while afterwards.
  task automatic send_char(input logic [CharW-1:0] code, input logic last);
    b64_in_t req;
    req.char_code = code;
    req.is_last   = last;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sent_chars++;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_str(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && (i == s.len() - 1));
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  // Mostly well-formed texts of 1..3 groups with optional trailing pad; some
  // carry a stray '=', a noise byte, or are cut short mid-group.
  task automatic make_text();
    int groups;
    int pads;
    text_q.delete();
    groups = $urandom_range(3, 1);
    for (int i = 0; i < 4 * groups; i++) text_q.push_back(b64_char($urandom_range(63)));
    pads = $urandom_range(2);
    for (int i = 0; i < pads; i++) text_q[text_q.size() - 1 - i] = ChPad;
    if ($urandom_range(9) == 0) text_q[$urandom_range(text_q.size() - 1)] = ChPad;
    case ($urandom_range(9))
      0: begin
        text_q[$urandom_range(text_q.size() - 1)] = CharW'($urandom_range(255));
      end
      1: begin
        repeat ($urandom_range(3, 1)) void'(text_q.pop_back());
      end
      default: ;
    endcase
  endtask

  // sender pause: valid dropped, all results in, then allow for characters
  // with no result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [BcW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [BcW-1:0] value, input logic with_hold,
                           input logic quiet);
    int target;
    wait_idle();
    write_limit(value);
    if (with_hold) hold_req = 1'b1;
    if (quiet) gap_pct = 0;
    target = sent_chars + PhaseChars;
    while (sent_chars < target) begin
      make_text();
      send_text();
    end
    gap_pct = 20;
  endtask

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full limit, then directed texts
    write_limit('1);
    send_str("TWFu", 1'b1);          // plain group, finished status
    send_str("Zz=9+/==", 1'b1);      // stray pad counts as zero; '==' trims to one byte
    send_str("QUI=", 1'b1);          // '=' trims to two bytes
    send_str("AB", 1'b0);            // bad symbol mid-text, rest dropped up to last
    send_char(8'h00, 1'b0);
    send_str("CD", 1'b1);
    send_str("A", 1'b0);             // bad symbol as the last character
    send_char(8'hFF, 1'b1);
    send_str("AB", 1'b1);            // text ends inside a group

    // random texts over several limits: zero overflows every group
    run_phase('0, 1'b0, 1'b0);
    run_phase(BcW'(4), 1'b1, 1'b0);
    run_phase(BcW'($urandom_range(12, 3)), 1'b0, 1'b1);
    run_phase(BcW'($urandom_range(24'hFFFFFF)), 1'b0, 1'b0);
    run_phase('1, 1'b0, 1'b0);

    wait_idle();
    if (mismatches == 0 && results_due == 0) begin
      $display("base64_stream_decoder_top_test: PASS");
    end else begin
      $display("base64_stream_decoder_top_test: FAIL");
    end
    $finish;
  end

endmodule
